// File: rtl/ptsd_pkg.sv
// ----------------------------------------------------------------------------
// ptsd_pkg - shared types and constants of the priority task scheduler
// Action codes, sequencer states, the result record and default sizes.
// ----------------------------------------------------------------------------
package ptsd_pkg;

    localparam int NUM_PRIOS_DEF  = 32;
    localparam int DELAY_BITS_DEF = 16;

    localparam int ACTION_W = 3;   // width of the action code
    localparam int PRIO_FW  = 5;   // width of the task_prio / next_prio fields
    localparam int TICKS_W  = 16;  // width of the delay_ticks field
    localparam int LOCK_W   = 8;   // width of the lock depth

    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_DELAY  = 3'd2,
        ACT_LOCK   = 3'd3,
        ACT_UNLOCK = 3'd4,
        ACT_START  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LOCK_W-1:0]  lock_level;
        logic               none_ready;
        logic [PRIO_FW-1:0] next_prio;
        logic               switch_request;
    } t_result;

endpackage

// File: rtl/ptsd_cnt_ram.sv
// ----------------------------------------------------------------------------
// ptsd_cnt_ram - delay counter store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptsd_cnt_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptsd_seq.sv
// ----------------------------------------------------------------------------
// ptsd_seq - scheduler sequencer
// Holds the ready/delayed maps, lock depth and running task. Each request
// walks all slots once through one shared decrement/compare unit: a tick
// counts delayed slots down, and every request finds the lowest ready slot.
// ----------------------------------------------------------------------------
module ptsd_seq
    import ptsd_pkg::*;
#(
    parameter int NUM_PRIOS  = NUM_PRIOS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF,
    parameter int PRIO_W     = $clog2(NUM_PRIOS),
    parameter int IDX_W      = $clog2(NUM_PRIOS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [PRIO_FW-1:0]    i_prio,
    input  logic [TICKS_W-1:0]    i_ticks,
    // result side
    input  logic                  i_out_free,
    output logic                  o_done,
    output t_result               o_result,
    // counter store
    output logic                  o_we,
    output logic [PRIO_W-1:0]     o_waddr,
    output logic [DELAY_BITS-1:0] o_wdata,
    output logic [PRIO_W-1:0]     o_raddr,
    input  logic [DELAY_BITS-1:0] i_rdata
);

    localparam logic [NUM_PRIOS-1:0]  P_ONE    = NUM_PRIOS'(1);
    localparam logic [DELAY_BITS-1:0] DLY_MAX  = '1;
    localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(NUM_PRIOS);

    t_state                r_state,   n_state;
    logic [IDX_W-1:0]      r_idx,     n_idx;
    logic [ACTION_W-1:0]   r_action,  n_action;
    logic [NUM_PRIOS-1:0]  r_ready,   n_ready;
    logic [NUM_PRIOS-1:0]  r_delayed, n_delayed;
    logic [LOCK_W-1:0]     r_lock,    n_lock;
    logic [PRIO_W-1:0]     r_cur,     n_cur;
    logic                  r_cur_vld, n_cur_vld;
    logic                  r_found,   n_found;
    logic [PRIO_W-1:0]     r_best,    n_best;
    logic                  r_resched, n_resched;
    logic                  r_tick,    n_tick;

    logic [TICKS_W-1:0]    w_ticks_nz;
    logic [DELAY_BITS-1:0] w_load;
    logic [IDX_W-1:0]      w_idx_m1;
    logic [PRIO_W-1:0]     w_slot;
    logic [NUM_PRIOS-1:0]  w_slot_bit;
    logic [DELAY_BITS-1:0] w_dec;
    logic                  w_expire;
    logic                  w_rdy_bit;
    logic                  w_sw;

    // delay load value: zero taken as one, saturated to the counter range
    assign w_ticks_nz = (i_ticks == '0) ? TICKS_W'(1) : i_ticks;
    assign w_load     = (32'(w_ticks_nz) > 32'(DLY_MAX)) ? DLY_MAX
                                                         : DELAY_BITS'(w_ticks_nz);

    // shared unit: slot r_idx-1 is processed while slot r_idx is read
    assign w_idx_m1   = r_idx - IDX_W'(1);
    assign w_slot     = w_idx_m1[PRIO_W-1:0];
    assign w_slot_bit = P_ONE << w_slot;
    assign w_dec      = (i_rdata != '0) ? (i_rdata - DELAY_BITS'(1)) : '0;
    assign w_expire   = r_tick && r_delayed[w_slot] && (w_dec == '0);
    assign w_rdy_bit  = r_ready[w_slot] || w_expire;

    assign o_raddr = r_idx[PRIO_W-1:0];
    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_ready   <= '0;
            r_delayed <= '0;
            r_lock    <= '0;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_found   <= 1'b0;
            r_resched <= 1'b0;
            r_tick    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_ready   <= n_ready;
            r_delayed <= n_delayed;
            r_lock    <= n_lock;
            r_cur     <= n_cur;
            r_cur_vld <= n_cur_vld;
            r_found   <= n_found;
            r_resched <= n_resched;
            r_tick    <= n_tick;
        end
    end

    // payload of the request in flight
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_best   <= n_best;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_action  = r_action;
        n_ready   = r_ready;
        n_delayed = r_delayed;
        n_lock    = r_lock;
        n_cur     = r_cur;
        n_cur_vld = r_cur_vld;
        n_found   = r_found;
        n_best    = r_best;
        n_resched = r_resched;
        n_tick    = r_tick;
        o_we      = 1'b0;
        o_waddr   = r_cur;
        o_wdata   = w_load;
        o_done    = 1'b0;
        w_sw      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state   = ST_WALK;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_best    = '0;
                    n_action  = i_action;
                    n_resched = 1'b0;
                    n_tick    = 1'b0;
                    case (i_action)
                        ACT_TICK: begin
                            n_tick    = 1'b1;
                            n_resched = 1'b1;
                        end
                        ACT_CREATE: begin
                            if (32'(i_prio) < 32'(NUM_PRIOS)) begin
                                n_ready   = r_ready | (P_ONE << PRIO_W'(i_prio));
                                n_delayed = r_delayed & ~(P_ONE << PRIO_W'(i_prio));
                            end
                        end
                        ACT_DELAY: begin
                            if (r_cur_vld) begin
                                o_we      = 1'b1;
                                n_delayed = r_delayed | (P_ONE << r_cur);
                                n_ready   = r_ready & ~(P_ONE << r_cur);
                                n_resched = 1'b1;
                            end
                        end
                        ACT_LOCK: begin
                            if (r_lock != LOCK_MAX) begin
                                n_lock = r_lock + LOCK_W'(1);
                            end
                        end
                        ACT_UNLOCK: begin
                            if (r_lock != '0) begin
                                n_lock    = r_lock - LOCK_W'(1);
                                n_resched = (r_lock == LOCK_W'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_WALK: begin
                n_idx = r_idx + IDX_W'(1);
                if (r_idx != '0) begin
                    if (r_tick && r_delayed[w_slot]) begin
                        o_we    = 1'b1;
                        o_waddr = w_slot;
                        o_wdata = w_dec;
                    end
                    if (w_expire) begin
                        n_delayed = r_delayed & ~w_slot_bit;
                        n_ready   = r_ready | w_slot_bit;
                    end
                    if (!r_found && w_rdy_bit) begin
                        n_found = 1'b1;
                        n_best  = w_slot;
                    end
                end
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (r_action == ACT_START) begin
                    if (r_found) begin
                        w_sw      = !r_cur_vld || (r_best != r_cur);
                        n_cur     = r_best;
                        n_cur_vld = 1'b1;
                    end
                end else if (r_resched && r_cur_vld && (r_lock == '0) && r_found
                             && (r_best != r_cur)) begin
                    w_sw  = 1'b1;
                    n_cur = r_best;
                end
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_cur     = r_cur;
                    n_cur_vld = r_cur_vld;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        o_result.switch_request = w_sw;
        o_result.next_prio      = n_cur_vld ? PRIO_FW'(n_cur) : '0;
        o_result.none_ready     = !r_found;
        o_result.lock_level     = r_lock;
    end

`ifndef SYNTHESIS
    a_maps_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_delayed) == '0)
        else $error("slot both ready and delayed");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("walk index out of range");

    a_switch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.switch_request |=> r_cur_vld)
        else $error("switch reported with no running task");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid |=> (r_state == ST_WALK) && (r_idx == '0))
        else $error("accepted request did not start a walk");
`endif

endmodule

// File: rtl/priority_task_scheduler_with_delays_top.sv
// Each request is accepted while idle, walks all slots through the shared decrement/compare
//   unit and then finishes; no new request is taken until the last one has finished, and the
//   finish waits while the output register is full.
// A finished result waits in the output register while the next request is taken.
// Reset (i_rst_n low, synchronous): maps, lock depth and running task cleared;
//   the counter store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays_top - bitmap RTOS scheduler with delays
// One task per priority slot (0 highest), tick countdown, lock depth, start.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delays_top
    import ptsd_pkg::*;
#(
    parameter int NUM_PRIOS  = NUM_PRIOS_DEF,   // 2 .. 32
    parameter int DELAY_BITS = DELAY_BITS_DEF   // 8 .. 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [4:0] task_prio, [20:5] delay_ticks, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] switch_request, [5:1] next_prio,
                                        // [6] none_ready, [14:7] lock_level, [15] zero
);

    localparam int PRIO_W = $clog2(NUM_PRIOS);
    localparam int IDX_W  = $clog2(NUM_PRIOS + 1);

    logic                  w_out_free;
    logic                  w_done;
    t_result               w_result;
    logic                  w_we;
    logic [PRIO_W-1:0]     w_waddr;
    logic [DELAY_BITS-1:0] w_wdata;
    logic [PRIO_W-1:0]     w_raddr;
    logic [DELAY_BITS-1:0] w_rdata;

    // output register: holds one result until the downstream side takes it
    logic                  r_m_valid;
    t_result               r_m_result;

    assign w_out_free = !r_m_valid || m_axis_tready;

    ptsd_seq #(
        .NUM_PRIOS  (NUM_PRIOS),
        .DELAY_BITS (DELAY_BITS),
        .PRIO_W     (PRIO_W),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_prio     (s_axis_tdata[4:0]),
        .i_ticks    (s_axis_tdata[20:5]),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_result   (w_result),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    // per-slot delay counters; a counter's value is used only while the slot's delayed flag is set
    ptsd_cnt_ram #(
        .DEPTH (NUM_PRIOS),
        .AW    (PRIO_W),
        .DW    (DELAY_BITS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_result};

endmodule

// File: sim/ptsd_checker.sv
// ----------------------------------------------------------------------------
// ptsd_checker - scoreboard for the priority task scheduler
// Watches both streams, predicts every result from accepted requests and
// compares each delivered result field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module ptsd_checker
    import ptsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [4:0] task_prio, [20:5] delay_ticks, rest zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] action
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [0] switch_request, [5:1] next_prio,
                                          // [6] none_ready, [14:7] lock_level, [15] zero
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int SLOTS = NUM_PRIOS_DEF;

    // shadow scheduler state
    logic [SLOTS-1:0]   sh_ready;
    logic [SLOTS-1:0]   sh_delayed;
    logic [TICKS_W-1:0] sh_count [SLOTS];
    logic [LOCK_W-1:0]  sh_lock;
    logic [PRIO_FW-1:0] sh_cur;
    logic               sh_cur_valid;

    t_result predicted_results [$];
    int      err_count = 0;
    int      checked_count = 0;

    function automatic logic [PRIO_FW-1:0] first_ready(input logic [SLOTS-1:0] map);
        logic [PRIO_FW-1:0] best;
        best = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (map[i]) best = PRIO_FW'(i);
        end
        return best;
    endfunction

    // reschedule attempt; true when the running slot changes
    function automatic logic try_switch();
        logic [PRIO_FW-1:0] best;
        if (!sh_cur_valid || sh_lock != '0 || sh_ready == '0) return 1'b0;
        best = first_ready(sh_ready);
        if (best == sh_cur) return 1'b0;
        sh_cur = best;
        return 1'b1;
    endfunction

    function automatic t_result predict_sched(input logic [2:0] act,
                                              input logic [PRIO_FW-1:0] prio,
                                              input logic [TICKS_W-1:0] ticks);
        t_result            r;
        logic               sw;
        logic [PRIO_FW-1:0] best;
        sw = 1'b0;
        case (act)
            ACT_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (sh_delayed[i]) begin
                        if (sh_count[i] != '0) sh_count[i] = sh_count[i] - TICKS_W'(1);
                        if (sh_count[i] == '0) begin
                            sh_delayed[i] = 1'b0;
                            sh_ready[i]   = 1'b1;
                        end
                    end
                end
                sw = try_switch();
            end
            ACT_CREATE: begin
                sh_ready[prio]   = 1'b1;
                sh_delayed[prio] = 1'b0;
            end
            ACT_DELAY: begin
                if (sh_cur_valid) begin
                    sh_count[sh_cur]   = (ticks == '0) ? TICKS_W'(1) : ticks;
                    sh_delayed[sh_cur] = 1'b1;
                    sh_ready[sh_cur]   = 1'b0;
                    sw = try_switch();
                end
            end
            ACT_LOCK: begin
                if (sh_lock != LOCK_MAX) sh_lock = sh_lock + LOCK_W'(1);
            end
            ACT_UNLOCK: begin
                if (sh_lock != '0) begin
                    sh_lock = sh_lock - LOCK_W'(1);
                    if (sh_lock == '0) sw = try_switch();
                end
            end
            ACT_START: begin
                if (sh_ready != '0) begin
                    best         = first_ready(sh_ready);
                    sw           = !sh_cur_valid || best != sh_cur;
                    sh_cur       = best;
                    sh_cur_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.switch_request = sw;
        r.next_prio      = sh_cur_valid ? sh_cur : '0;
        r.none_ready     = (sh_ready == '0);
        r.lock_level     = sh_lock;
        return r;
    endfunction

    function automatic void report(input string what, input logic [15:0] exp_v,
                                   input logic [15:0] act_v);
        err_count++;
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got_r;
        if (!i_rst_n) begin
            sh_ready     = '0;
            sh_delayed   = '0;
            sh_lock      = '0;
            sh_cur       = '0;
            sh_cur_valid = 1'b0;
            for (int i = 0; i < SLOTS; i++) sh_count[i] = '0;
            predicted_results.delete();
        end else begin
            // results first: one delivered now belongs to an earlier request
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r = t_result'(i_m_axis_tdata[14:0]);
                if (predicted_results.size() == 0) begin
                    report("unexpected result", 16'h0, i_m_axis_tdata);
                end else begin
                    exp_r = predicted_results.pop_front();
                    checked_count++;
                    if (got_r.switch_request != exp_r.switch_request)
                        report("switch_request", 16'(exp_r.switch_request),
                               16'(got_r.switch_request));
                    if (got_r.next_prio != exp_r.next_prio)
                        report("next_prio", 16'(exp_r.next_prio), 16'(got_r.next_prio));
                    if (got_r.none_ready != exp_r.none_ready)
                        report("none_ready", 16'(exp_r.none_ready), 16'(got_r.none_ready));
                    if (got_r.lock_level != exp_r.lock_level)
                        report("lock_level", 16'(exp_r.lock_level), 16'(got_r.lock_level));
                    if (i_m_axis_tdata[15] != 1'b0)
                        report("pad bit", 16'h0, 16'(i_m_axis_tdata[15]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                predicted_results.push_back(predict_sched(i_s_axis_tuser,
                                                          i_s_axis_tdata[4:0],
                                                          i_s_axis_tdata[20:5]));
        end
        o_errors  <= err_count;
        o_pending <= predicted_results.size();
        o_checked <= checked_count;
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top for the priority task scheduler
// Drives directed and random scheduler requests through four idle/stall
// phases, with a long output stall and a lock saturation run; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
    import ptsd_pkg::*;
();

    localparam int DRAIN_CYCLES = 40;        // quiet time after the last result, longer than one request's walk
    localparam int RANDOM_PER_PHASE = 370;   // with directed and lock runs, ~2000 requests

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [4:0] task_prio, [20:5] delay_ticks, rest zero
    logic [2:0]  s_axis_tuser = '0;    // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] switch_request, [5:1] next_prio,
                                       // [6] none_ready, [14:7] lock_level, [15] zero

    int errors;
    int pending;
    int checked;
    int req_sent = 0;
    int idle_pct = 0;     // sender idle chance, used by the stimulus process only
    int stall_pct = 0;    // receiver stall chance, updated with NBA
    logic hold_recv = 1'b0;

    always #5 i_clk = ~i_clk;

    priority_task_scheduler_with_delays_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ptsd_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Result side: random back-pressure, or a solid hold-off while hold_recv
    // is up. This is the only driver of m_axis_tready.
    always @(posedge i_clk) begin
        if (hold_recv) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request, with random idle cycles ahead of it, and return on
    // the edge that accepts it. tvalid stays high; the next call or the drain
    // lowers it, so it never gets two NBAs in one step.
    task automatic send_req(input logic [2:0] act, input logic [4:0] prio,
                            input logic [15:0] ticks);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, ticks, prio};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        req_sent++;
    endtask

    // Sender pause: nothing offered until every predicted result is back,
    // then a quiet drain period.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);      // lets the checker count the last accept
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: creates feed the ready set, delays and
    // ticks move tasks in and out, lock/unlock kept near balance so that
    // reschedules still happen. Fields unused by an action carry noise.
    task automatic send_random_req();
        int          pick;
        int          dsel;
        logic [2:0]  act;
        logic [4:0]  prio;
        logic [15:0] ticks;
        pick  = $urandom_range(99);
        prio  = 5'($urandom_range(31));
        ticks = 16'($urandom);
        if (pick < 3)       act = 3'($urandom_range(7, 6));   // undefined codes
        else if (pick < 22) act = ACT_CREATE;
        else if (pick < 26) act = ACT_START;
        else if (pick < 42) act = ACT_DELAY;
        else if (pick < 78) act = ACT_TICK;
        else if (pick < 88) act = ACT_LOCK;
        else                act = ACT_UNLOCK;
        if (act == ACT_DELAY) begin
            dsel = $urandom_range(9);
            if (dsel == 0)      ticks = 16'd0;        // zero delay loads one
            else if (dsel == 1) ticks = 16'hFFFF;     // longest delay
            else if (dsel > 2)  ticks = 16'($urandom_range(6, 1));
        end
        send_req(act, prio, ticks);
    endtask

    initial begin
        int ph;
        // reset held at the start, once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed opening ----
        send_req(ACT_TICK,   5'd0,  16'd0);     // tick with nothing delayed
        send_req(ACT_DELAY,  5'd0,  16'd5);     // delay with no running task
        send_req(ACT_UNLOCK, 5'd0,  16'd0);     // unlock at depth zero
        send_req(ACT_START,  5'd0,  16'd0);     // start with empty ready set
        send_req(3'd6,       5'd31, 16'hFFFF);  // undefined action codes
        send_req(3'd7,       5'd31, 16'hFFFF);
        send_req(ACT_CREATE, 5'd31, 16'd0);
        send_req(ACT_CREATE, 5'd0,  16'd0);
        send_req(ACT_CREATE, 5'd5,  16'd0);
        send_req(ACT_TICK,   5'd0,  16'd0);     // tick before start: no switch
        send_req(ACT_START,  5'd0,  16'd0);     // first task picked
        send_req(ACT_DELAY,  5'd0,  16'd0);     // zero delay, switch away
        send_req(ACT_TICK,   5'd0,  16'd0);     // wakes slot 0, switch back
        send_req(ACT_LOCK,   5'd0,  16'd0);
        send_req(ACT_DELAY,  5'd0,  16'd3);     // locked: task keeps running
        send_req(ACT_UNLOCK, 5'd0,  16'd0);     // release reschedules
        send_req(ACT_DELAY,  5'd0,  16'hFFFF);  // longest delay
        send_req(ACT_DELAY,  5'd0,  16'd2);     // ready set may empty out
        send_req(ACT_DELAY,  5'd0,  16'd2);
        send_req(ACT_TICK,   5'd0,  16'd0);
        send_req(ACT_TICK,   5'd0,  16'd0);
        send_req(ACT_CREATE, 5'd0,  16'd0);     // create clears a delayed flag
        send_req(ACT_START,  5'd0,  16'd0);     // start while running
        send_req(ACT_TICK,   5'd0,  16'd0);
        wait_results();

        // ---- random phases ----
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 75; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 75; end
                default: begin idle_pct = 33; stall_pct <= 33; end
            endcase
            if (ph == 0) begin
                // long output hold-off while requests keep coming, so the
                // block fills up and drops s_axis_tready
                hold_recv <= 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_recv <= 1'b0;
                    end
                join_none
            end
            repeat (RANDOM_PER_PHASE) send_random_req();
            if (ph == 2) begin
                // lock depth driven past saturation and back down to zero
                repeat (258) send_req(ACT_LOCK, 5'($urandom), 16'($urandom));
                repeat (258) send_req(ACT_UNLOCK, 5'($urandom), 16'($urandom));
            end
            wait_results();
        end

        $display("tb: %0d requests sent, %0d results checked over four idle/stall phases,",
                 req_sent, checked);
        $display("tb: incl. a 300-cycle output hold-off and lock depth saturation");
        if (errors == 0 && pending == 0) begin
            $display("priority_task_scheduler_with_delays_top: match");
        end else begin
            $display("priority_task_scheduler_with_delays_top: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("priority_task_scheduler_with_delays_top: mismatch");
        $finish;
    end

endmodule
